[hdl/babd_pkg.sv]
// ----------------------------------------------------------------------------
// Box absorbing boundary damper: shared definitions
// Field widths, fixed-point constants, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package babd_pkg;

  // Field widths of the streams and the register file.
  localparam int COORD_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int BORD_W     = 10;
  localparam int DATA_W     = 24;
  localparam int FACTOR_W   = 17;
  localparam int FRAC_W     = 16;
  localparam int CFG_DATA_W = 13;

  // Signed width for the region tests and axis distances.
  localparam int REG_W = 15;

  // Sample times factor, before the rounding shift.
  localparam int PROD_W = DATA_W + FACTOR_W;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 72;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;
  localparam int                  ROUND_HALF = 1 << (FRAC_W - 1);

  localparam int unsigned DAMP_EXPONENT_MILLI_DEF = 30;
  localparam int unsigned EXP_TABLE_ENTRIES_DEF   = 1024;

  localparam logic [SIZE_W-1:0] GRID_RESET   = 13'd256;
  localparam logic [SIZE_W-1:0] INNER_RESET  = 13'd200;
  localparam logic [BORD_W-1:0] BORDER_RESET = 10'd4;
  localparam logic [BORD_W-1:0] ABSORB_RESET = 10'd24;

  typedef enum logic [2:0] {
    REG_GRID_X,
    REG_GRID_Y,
    REG_GRID_Z,
    REG_INNER_X,
    REG_INNER_Y,
    REG_INNER_Z,
    REG_BORDER,
    REG_ABSORB
  } cfg_idx_t;

endpackage

`default_nettype wire

[hdl/box_absorbing_boundary_damper.sv]
// ----------------------------------------------------------------------------
// Box absorbing boundary damper
// Scales two wavefield samples of a grid point by a Gaussian sponge factor
// that depends on the point's Chebyshev distance to the interior box.
//
//   Channel  Direction  Handshake                Payload
//   s_*      in         s_tvalid / s_tready      s_tdata: x, y, z, p, q
//   m_*      out        m_tvalid / m_tready      m_tdata: p_out, q_out, factor
//   cfg_*    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One beat per cycle while the output buffer has room. The divider that forms
// the table index, one quotient bit per stage, makes up most of the pipeline
// depth.
// rst loads the register defaults and clears the pipeline valid bits.
// A two-entry output buffer keeps s_tready high while one result waits; when
// both entries are full the whole pipeline holds.
// ----------------------------------------------------------------------------
`default_nettype none

module box_absorbing_boundary_damper #(
  parameter int unsigned DAMP_EXPONENT_MILLI = babd_pkg::DAMP_EXPONENT_MILLI_DEF,
  parameter int unsigned EXP_TABLE_ENTRIES   = babd_pkg::EXP_TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            s_tvalid,
  output logic                            s_tready,
  // point_x[11:0], point_y[23:12], point_z[35:24], field_p_in[59:36],
  // field_q_in[83:60], zero pad[87:84]
  input  logic [babd_pkg::IN_TDATA_W-1:0] s_tdata,

  output logic                             m_tvalid,
  input  logic                             m_tready,
  // field_p_out[23:0], field_q_out[47:24], damp_factor[64:48], zero pad[71:65]
  output logic [babd_pkg::OUT_TDATA_W-1:0] m_tdata,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  babd_pkg::cfg_idx_t              cfg_index,
  input  logic [babd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COORD_W  = babd_pkg::COORD_W;
  localparam int SIZE_W   = babd_pkg::SIZE_W;
  localparam int BORD_W   = babd_pkg::BORD_W;
  localparam int DATA_W   = babd_pkg::DATA_W;
  localparam int FACTOR_W = babd_pkg::FACTOR_W;
  localparam int FRAC_W   = babd_pkg::FRAC_W;
  localparam int REG_W    = babd_pkg::REG_W;
  localparam int PROD_W   = babd_pkg::PROD_W;

  localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
  localparam int SQ_W  = 2 * BORD_W;
  localparam int NUM_W = SQ_W + IDX_W + 1;
  localparam int DL    = IDX_W + 1;

  typedef struct packed {
    logic [2:0][SIZE_W-1:0] grid;
    logic [2:0][SIZE_W-1:0] inner;
    logic [BORD_W-1:0]      border;
    logic [BORD_W-1:0]      absorb;
  } cfg_t;

  // Values derived from the registers, kept ready for the region tests.
  typedef struct packed {
    logic [REG_W-1:0]      ba;
    logic [REG_W-1:0]      b;
    logic [2:0][REG_W-1:0] hi_in;
    logic [2:0][REG_W-1:0] hi_out;
    logic [2:0][REG_W-1:0] thr;
    logic [2:0][REG_W-1:0] off;
    logic [BORD_W-1:0]     a;
    logic [SQ_W-1:0]       a_sq;
    logic                  a_zero;
  } geo_t;

  typedef struct packed {
    logic              unity;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] q;
  } side_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [DATA_W-1:0]   q;
    logic [DATA_W-1:0]   p;
  } res_t;

  // --------------------------------------------------------------------------
  // Register file
  // --------------------------------------------------------------------------
  cfg_t cfg;
  cfg_t cfg_next;
  geo_t geo;
  geo_t geo_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (rst) begin
      cfg_next.grid   = {3{babd_pkg::GRID_RESET}};
      cfg_next.inner  = {3{babd_pkg::INNER_RESET}};
      cfg_next.border = babd_pkg::BORDER_RESET;
      cfg_next.absorb = babd_pkg::ABSORB_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        babd_pkg::REG_GRID_X:  cfg_next.grid[0]  = cfg_data;
        babd_pkg::REG_GRID_Y:  cfg_next.grid[1]  = cfg_data;
        babd_pkg::REG_GRID_Z:  cfg_next.grid[2]  = cfg_data;
        babd_pkg::REG_INNER_X: cfg_next.inner[0] = cfg_data;
        babd_pkg::REG_INNER_Y: cfg_next.inner[1] = cfg_data;
        babd_pkg::REG_INNER_Z: cfg_next.inner[2] = cfg_data;
        babd_pkg::REG_BORDER:  cfg_next.border   = cfg_data[BORD_W-1:0];
        babd_pkg::REG_ABSORB:  cfg_next.absorb   = cfg_data[BORD_W-1:0];
        default:               cfg_next          = cfg;
      endcase
    end
  end

  // Derived values follow the next register value, so they are current in
  // the same cycle as the registers themselves.
  always_comb begin
    logic [REG_W-1:0] ba_w;
    ba_w = REG_W'(cfg_next.border) + REG_W'(cfg_next.absorb);
    geo_next.ba     = ba_w;
    geo_next.b      = REG_W'(cfg_next.border);
    geo_next.a      = cfg_next.absorb;
    geo_next.a_sq   = SQ_W'(cfg_next.absorb) * SQ_W'(cfg_next.absorb);
    geo_next.a_zero = (cfg_next.absorb == '0);
    for (int i = 0; i < 3; i++) begin
      geo_next.hi_in[i]  = REG_W'(cfg_next.grid[i]) - ba_w;
      geo_next.hi_out[i] = REG_W'(cfg_next.grid[i]) - REG_W'(cfg_next.border);
      geo_next.thr[i]    = REG_W'(cfg_next.inner[i]) + ba_w;
      geo_next.off[i]    = REG_W'(cfg_next.inner[i]) + ba_w - REG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
    geo <= geo_next;
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage moves together while the output buffer
  // has room.
  // --------------------------------------------------------------------------
  logic adv;
  logic skid_valid;
  logic out_valid;

  assign adv      = !skid_valid;
  assign s_tready = adv;

  // Stage 0: input register.
  logic                     v0;
  logic [2:0][COORD_W-1:0]  crd0;
  side_t                    side0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crd0        <= s_tdata[3*COORD_W-1:0];
      side0.unity <= 1'b0;
      side0.p     <= s_tdata[3*COORD_W +: DATA_W];
      side0.q     <= s_tdata[3*COORD_W+DATA_W +: DATA_W];
    end
  end

  // Stage 1: region tests and the signed distance along each axis.
  logic                  v1;
  side_t                 side1;
  logic [2:0][REG_W-1:0] dist1;
  logic [2:0][REG_W-1:0] dist1_next;
  logic                  unity1_next;

  always_comb begin
    logic [REG_W-1:0] c;
    logic [2:0]       in_in;
    logic [2:0]       in_sh;
    for (int i = 0; i < 3; i++) begin
      c        = REG_W'(crd0[i]);
      in_in[i] = ($signed(c) >= $signed(geo.ba)) && ($signed(c) < $signed(geo.hi_in[i]));
      in_sh[i] = ($signed(c) >= $signed(geo.b)) && ($signed(c) < $signed(geo.hi_out[i]));
      dist1_next[i] = ($signed(c) >= $signed(geo.thr[i])) ? (c - geo.off[i])
                                                          : (geo.ba - c);
    end
    unity1_next = geo.a_zero || (&in_in) || !(&in_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist1       <= dist1_next;
      side1.unity <= unity1_next;
      side1.p     <= side0.p;
      side1.q     <= side0.q;
    end
  end

  // Stage 2: largest of the three distances.
  logic             v2;
  side_t            side2;
  logic [REG_W-1:0] dmax2;
  logic [REG_W-1:0] dmax2_next;

  always_comb begin
    logic [REG_W-1:0] m01;
    m01        = ($signed(dist1[1]) > $signed(dist1[0])) ? dist1[1] : dist1[0];
    dmax2_next = ($signed(dist1[2]) > $signed(m01)) ? dist1[2] : m01;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmax2 <= dmax2_next;
      side2 <= side1;
    end
  end

  // Stage 3: magnitude, held to the shell thickness.
  logic              v3;
  side_t             side3;
  logic [BORD_W-1:0] d3;
  logic [BORD_W-1:0] d3_next;

  always_comb begin
    logic [REG_W-1:0] dabs;
    dabs    = dmax2[REG_W-1] ? (REG_W'(0) - dmax2) : dmax2;
    d3_next = (dabs > REG_W'(geo.a)) ? geo.a : dabs[BORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d3    <= d3_next;
      side3 <= side2;
    end
  end

  // Stage 4: square of the distance.
  logic            v4;
  side_t           side4;
  logic [SQ_W-1:0] dsq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dsq4  <= SQ_W'(d3) * SQ_W'(d3);
      side4 <= side3;
    end
  end

  // Stage 5: dividend of the index, with half the divisor added so the
  // quotient rounds to nearest.
  logic             v5;
  side_t            side5;
  logic [NUM_W-1:0] num5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num5  <= NUM_W'(dsq4) * NUM_W'(EXP_TABLE_ENTRIES - 1)
             + NUM_W'(geo.a_sq[SQ_W-1:1]);
      side5 <= side4;
    end
  end

  // Index division, then the table read. The side data rides alongside.
  logic [IDX_W-1:0]    idx;
  logic [FACTOR_W-1:0] rom_data;
  logic [DL-1:0]       vdl;
  side_t               side_dl [DL];

  babd_div #(
    .NUM_W (NUM_W),
    .DEN_W (SQ_W),
    .QUO_W (IDX_W)
  ) u_div (
    .clk (clk),
    .en  (adv),
    .num (num5),
    .den (geo.a_sq),
    .quo (idx)
  );

  babd_exp_rom #(
    .DAMP_EXPONENT_MILLI (DAMP_EXPONENT_MILLI),
    .EXP_TABLE_ENTRIES   (EXP_TABLE_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .en   (adv),
    .addr (idx),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vdl <= '0;
    end else if (adv) begin
      vdl <= {vdl[DL-2:0], v5};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dl[0] <= side5;
      for (int j = 1; j < DL; j++) begin
        side_dl[j] <= side_dl[j-1];
      end
    end
  end

  // Final stage: pick the factor and scale both samples.
  logic                     vm;
  logic [FACTOR_W-1:0]      fac_m;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_q;
  logic [FACTOR_W-1:0]      factor_sel;
  logic signed [FACTOR_W:0] factor_s;

  assign factor_sel = side_dl[DL-1].unity ? babd_pkg::FACTOR_ONE : rom_data;
  assign factor_s   = $signed({1'b0, factor_sel});

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= vdl[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fac_m  <= factor_sel;
      prod_p <= PROD_W'($signed(side_dl[DL-1].p) * factor_s)
              + PROD_W'(babd_pkg::ROUND_HALF);
      prod_q <= PROD_W'($signed(side_dl[DL-1].q) * factor_s)
              + PROD_W'(babd_pkg::ROUND_HALF);
    end
  end

  // --------------------------------------------------------------------------
  // Output register with a skid entry behind it.
  // --------------------------------------------------------------------------
  res_t res_new;
  res_t out_data;
  res_t skid_data;
  logic push;
  logic pop;

  assign res_new.p      = prod_p[FRAC_W +: DATA_W];
  assign res_new.q      = prod_q[FRAC_W +: DATA_W];
  assign res_new.factor = fac_m;

  assign push = vm && adv;
  assign pop  = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !m_tready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !m_tready) begin
        skid_data <= res_new;
      end else begin
        out_data <= res_new;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = babd_pkg::OUT_TDATA_W'(out_data);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a beat while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_tready))
    else $error("skid entry filled although the output beat could leave");

  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.factor <= babd_pkg::FACTOR_ONE))
    else $error("damping factor above one");

endmodule

`default_nettype wire

[hdl/babd_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider; it does not enforce a steady divisor.
// One quotient bit per stage, most significant first. The quotient must fit
// QUO_W bits; the user must hold the divisor steady while items are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module babd_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 20,
  parameter int QUO_W = 10
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int BIT = QUO_W - 1 - s;

    logic [NUM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [NUM_W-1:0] trial;
    logic             fits;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = NUM_W'(den) << BIT;
    assign fits  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[s] <= quo_in | (QUO_W'(fits) << BIT);
      end
    end

    // The last stage has no use for its remainder.
    if (s < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= fits ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule

`default_nettype wire

[hdl/babd_exp_rom.sv]
// ----------------------------------------------------------------------------
// Gaussian decay table
// Entry k holds exp(-F*k/(E-1)) in Q1.16, F = DAMP_EXPONENT_MILLI/1000 and
// E = EXP_TABLE_ENTRIES. Contents are worked out at elaboration; the read
// data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module babd_exp_rom #(
  parameter int unsigned DAMP_EXPONENT_MILLI = babd_pkg::DAMP_EXPONENT_MILLI_DEF,
  parameter int unsigned EXP_TABLE_ENTRIES   = babd_pkg::EXP_TABLE_ENTRIES_DEF,
  localparam int         ADDR_W              = $clog2(EXP_TABLE_ENTRIES)
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ADDR_W-1:0]             addr,
  output logic [babd_pkg::FACTOR_W-1:0] data
);

  localparam logic [63:0] EXP_DEN         = 64'd1000 * 64'(EXP_TABLE_ENTRIES - 1);
  localparam logic [63:0] ONE_Q32         = 64'h1_0000_0000;
  localparam logic [63:0] EXP_NEG_ONE_Q32 = 64'd1580030169;
  localparam int          TAYLOR_TERMS    = 24;

  // exp of the fraction by a Taylor series in Q32, then one factor of exp(-1)
  // for each whole unit of the exponent.
  function automatic logic [babd_pkg::FACTOR_W-1:0] rom_entry(input logic [63:0] k);
    logic [63:0] xq;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] term;
    logic [63:0] r;
    longint      sum;
    xq    = (64'(DAMP_EXPONENT_MILLI) * k * ONE_Q32 + EXP_DEN / 2) / EXP_DEN;
    whole = xq >> 32;
    frac  = xq & 64'hFFFF_FFFF;
    term  = ONE_Q32;
    sum   = longint'(ONE_Q32);
    for (int i = 1; i <= TAYLOR_TERMS; i++) begin
      term = ((term * frac) >> 32) / 64'(i);
      if ((i % 2) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    r = (sum > 0) ? 64'(sum) : 64'd0;
    for (longint unsigned j = 0; j < whole; j++) begin
      r = (r * EXP_NEG_ONE_Q32 + 64'h8000_0000) >> 32;
    end
    r = (r + 64'h8000) >> 16;
    if (r > 64'(babd_pkg::FACTOR_ONE)) begin
      r = 64'(babd_pkg::FACTOR_ONE);
    end
    return r[babd_pkg::FACTOR_W-1:0];
  endfunction

  logic [babd_pkg::FACTOR_W-1:0] rom_tbl [EXP_TABLE_ENTRIES];

  for (genvar k = 0; k < EXP_TABLE_ENTRIES; k++) begin : g_entry
    localparam logic [babd_pkg::FACTOR_W-1:0] ENTRY = rom_entry(64'(k));
    assign rom_tbl[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom_tbl[addr];
    end
  end

endmodule

`default_nettype wire

[bench/tb_box_absorbing_boundary_damper.sv]
// ----------------------------------------------------------------------------
// Testbench for the box absorbing boundary damper
// Streams grid points through the block under several register settings and
// checks every result beat against a cycle-free model of the sponge factor
// and the rounded sample scaling; both sides idle at random in most phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_box_absorbing_boundary_damper;
  import babd_pkg::*;

  localparam int TABLE_N      = EXP_TABLE_ENTRIES_DEF;
  localparam int MILLI        = DAMP_EXPONENT_MILLI_DEF;
  localparam int PIPE_LATENCY = $clog2(EXP_TABLE_ENTRIES_DEF) + 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [2:0][SIZE_W-1:0] grid;
    logic [2:0][SIZE_W-1:0] inner;
    logic [SIZE_W-1:0]      bw;
    logic [SIZE_W-1:0]      aw;
  } reg_set_t;

  typedef struct {
    logic [DATA_W-1:0]   p;
    logic [DATA_W-1:0]   q;
    logic [FACTOR_W-1:0] factor;
  } damped_t;

  typedef struct {
    logic [COORD_W-1:0] x, y, z;
    logic [DATA_W-1:0]  p, q;
    bit                 passes;  // factor is one, so the samples come back as sent
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index = REG_GRID_X;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  box_absorbing_boundary_damper u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  logic [FACTOR_W-1:0] gauss_rom [TABLE_N];
  reg_set_t            live_regs;
  damped_t             pending_damped [$];
  int                  err_count = 0;
  int                  cycle_count = 0;
  int                  src_idle_pct = 0;
  int                  sink_idle_pct = 0;

  // Directed points under the reset settings: grid 256, inner 200, border 4,
  // absorb 24, so the interior runs from 28 to 227 and the shell from 4 to 251.
  probe_t probes [16] = '{
    '{12'd128,  12'd128,  12'd128,  24'h7FFFFF, 24'h800000, 1'b1},
    '{12'd0,    12'd128,  12'd128,  24'h800000, 24'h7FFFFF, 1'b1},
    '{12'd4095, 12'd4095, 12'd4095, 24'hFFFFFF, 24'h000001, 1'b1},
    '{12'd28,   12'd128,  12'd128,  24'h003039, 24'hFF2BCF, 1'b1},
    '{12'd227,  12'd227,  12'd227,  24'h555555, 24'hAAAAAA, 1'b1},
    '{12'd252,  12'd128,  12'd128,  24'h123456, 24'h000000, 1'b1},
    '{12'd128,  12'd3,    12'd128,  24'h7FFFFF, 24'h7FFFFF, 1'b1},
    '{12'd128,  12'd128,  12'd252,  24'h800000, 24'h800000, 1'b1},
    '{12'd4,    12'd128,  12'd128,  24'h7FFFFF, 24'h800000, 1'b0},
    '{12'd27,   12'd128,  12'd128,  24'h7FFFFF, 24'h800000, 1'b0},
    '{12'd228,  12'd128,  12'd128,  24'hFFFFFF, 24'h000001, 1'b0},
    '{12'd251,  12'd128,  12'd128,  24'h400000, 24'hC00000, 1'b0},
    '{12'd128,  12'd10,   12'd128,  24'h000100, 24'hFFFF00, 1'b0},
    '{12'd128,  12'd128,  12'd240,  24'h0ABCDE, 24'hF54322, 1'b0},
    '{12'd10,   12'd10,   12'd10,   24'h7FFFFF, 24'h800000, 1'b0},
    '{12'd4,    12'd251,  12'd4,    24'hFFFFFF, 24'h7FFFFF, 1'b0}
  };

  // Q1.16 value of exp(-F*k/(N-1)): a truncated Taylor series on the fraction
  // of the exponent, then one multiply by exp(-1) per whole unit.
  function automatic logic [FACTOR_W-1:0] gauss_entry(input longint unsigned k);
    longint unsigned den, xq, whole, frac, term, r;
    longint          sum;
    den   = 64'd1000 * 64'(TABLE_N - 1);
    xq    = (64'(MILLI) * k * (64'd1 << 32) + den / 2) / den;
    whole = xq >> 32;
    frac  = xq & 64'hFFFF_FFFF;
    term  = 64'd1 << 32;
    sum   = 64'sd1 <<< 32;
    for (int i = 1; i <= 24; i++) begin
      term = ((term * frac) >> 32) / 64'(i);
      if (i % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    r = (sum > 0) ? longint'(sum) : 64'd0;
    for (longint unsigned j = 0; j < whole; j++)
      r = (r * 64'd1580030169 + (64'd1 << 31)) >> 32;
    r = (r + 64'd32768) >> 16;
    if (r > 64'd65536) r = 64'd65536;
    return r[FACTOR_W-1:0];
  endfunction

  function automatic logic [FACTOR_W-1:0] sponge_factor(input logic [COORD_W-1:0] x,
                                                         input logic [COORD_W-1:0] y,
                                                         input logic [COORD_W-1:0] z);
    longint c [3];
    longint b, a, s, n, base, d, dd, a2, k;
    bit     core, shell;
    c[0]  = longint'(x);
    c[1]  = longint'(y);
    c[2]  = longint'(z);
    b     = longint'(live_regs.bw[BORD_W-1:0]);
    a     = longint'(live_regs.aw[BORD_W-1:0]);
    base  = b + a;
    core  = 1'b1;
    shell = 1'b1;
    d     = 0;
    if (a == 0) return FACTOR_ONE;
    for (int i = 0; i < 3; i++) begin
      s = longint'(live_regs.grid[i]);
      if (!(c[i] >= base && c[i] < s - base)) core = 1'b0;
      if (!(c[i] >= b && c[i] < s - b)) shell = 1'b0;
    end
    if (core || !shell) return FACTOR_ONE;
    // Signed Chebyshev distance; it goes negative when the inner size does not
    // agree with the grid, and is then folded and capped at the shell width.
    for (int i = 0; i < 3; i++) begin
      n  = longint'(live_regs.inner[i]);
      dd = (c[i] >= base + n) ? c[i] - base - n + 1 : base - c[i];
      if (i == 0 || dd > d) d = dd;
    end
    if (d < 0) d = -d;
    if (d > a) d = a;
    a2 = a * a;
    k  = (d * d * (TABLE_N - 1) + a2 / 2) / a2;
    if (k > TABLE_N - 1) k = TABLE_N - 1;
    return gauss_rom[k];
  endfunction

  function automatic logic [DATA_W-1:0] scale_sample(input logic [DATA_W-1:0] smp,
                                                      input logic [FACTOR_W-1:0] f);
    longint prod;
    prod = longint'($signed(smp)) * longint'(f) + 32768;
    return prod[DATA_W+FRAC_W-1:FRAC_W];
  endfunction

  function automatic damped_t damp_point(input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y,
                                         input logic [COORD_W-1:0] z,
                                         input logic [DATA_W-1:0] p,
                                         input logic [DATA_W-1:0] q);
    damped_t r;
    r.factor = sponge_factor(x, y, z);
    r.p      = scale_sample(p, r.factor);
    r.q      = scale_sample(q, r.factor);
    return r;
  endfunction

  function automatic reg_set_t make_regs(input int gx, input int gy, input int gz,
                                         input int ix, input int iy, input int iz,
                                         input int bw, input int aw);
    reg_set_t r;
    r.grid[0]  = SIZE_W'(gx);
    r.grid[1]  = SIZE_W'(gy);
    r.grid[2]  = SIZE_W'(gz);
    r.inner[0] = SIZE_W'(ix);
    r.inner[1] = SIZE_W'(iy);
    r.inner[2] = SIZE_W'(iz);
    r.bw       = SIZE_W'(bw);
    r.aw       = SIZE_W'(aw);
    return r;
  endfunction

  // Mostly points near the shell faces or inside the grid, some anywhere.
  function automatic logic [COORD_W-1:0] pick_coord(input int axis);
    int s, b, a, lim;
    s   = int'(live_regs.grid[axis]);
    b   = int'(live_regs.bw[BORD_W-1:0]);
    a   = int'(live_regs.aw[BORD_W-1:0]);
    lim = (s + 2 > 4095) ? 4095 : s + 2;
    case ($urandom_range(9))
      0:       return COORD_W'($urandom);
      1, 2:    return COORD_W'(b + int'($urandom_range(a)));
      3, 4:    return COORD_W'(s - b - 1 - int'($urandom_range(a)));
      default: return COORD_W'($urandom_range(lim));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic push_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z, input logic [DATA_W-1:0] p,
                            input logic [DATA_W-1:0] q, input damped_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, q, p, z, y, x};
    do @(posedge clk); while (!s_tready);
    pending_damped.push_back(want);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last beat.
  task automatic cfg_beat(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input reg_set_t rs);
    cfg_beat(REG_GRID_X, rs.grid[0]);
    cfg_beat(REG_GRID_Y, rs.grid[1]);
    cfg_beat(REG_GRID_Z, rs.grid[2]);
    cfg_beat(REG_INNER_X, rs.inner[0]);
    cfg_beat(REG_INNER_Y, rs.inner[1]);
    cfg_beat(REG_INNER_Z, rs.inner[2]);
    cfg_beat(REG_BORDER, rs.bw);
    cfg_beat(REG_ABSORB, rs.aw);
    cfg_valid <= 1'b0;
    live_regs = rs;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_damped.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    damped_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_damped.size() == 0) begin
        $display("%0t: result beat with nothing expected: %h", $time, m_tdata);
        err_count++;
      end else begin
        want = pending_damped.pop_front();
        if (m_tdata[23:0] !== want.p) begin
          $display("%0t: field_p_out expected %0d actual %0d", $time,
                   $signed(want.p), $signed(m_tdata[23:0]));
          err_count++;
        end
        if (m_tdata[47:24] !== want.q) begin
          $display("%0t: field_q_out expected %0d actual %0d", $time,
                   $signed(want.q), $signed(m_tdata[47:24]));
          err_count++;
        end
        if (m_tdata[64:48] !== want.factor) begin
          $display("%0t: damp_factor expected %0d actual %0d", $time,
                   want.factor, m_tdata[64:48]);
          err_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    reg_set_t           settings [$];
    logic [COORD_W-1:0] px, py, pz;
    logic [DATA_W-1:0]  sp, sq;
    int                 b, a, g;
    reg_set_t           rs;

    for (int k = 0; k < TABLE_N; k++) gauss_rom[k] = gauss_entry(longint'(k));
    live_regs = make_regs(GRID_RESET, GRID_RESET, GRID_RESET, INNER_RESET, INNER_RESET,
                          INNER_RESET, BORDER_RESET, ABSORB_RESET);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct  = 12;
    sink_idle_pct = 55;
    foreach (probes[i]) begin
      if (probes[i].passes)
        push_point(probes[i].x, probes[i].y, probes[i].z, probes[i].p, probes[i].q,
                   '{probes[i].p, probes[i].q, FACTOR_ONE});
      else
        push_point(probes[i].x, probes[i].y, probes[i].z, probes[i].p, probes[i].q,
                   damp_point(probes[i].x, probes[i].y, probes[i].z,
                              probes[i].p, probes[i].q));
    end

    // Largest sizes and widths, then the smallest ones.
    settings.push_back(make_regs(4096, 4096, 4096, 1, 1, 1, 1023, 1023));
    settings.push_back(make_regs(1, 1, 1, 1, 1, 1, 0, 1));
    // An empty shell: every point passes through.
    settings.push_back(make_regs(64, 64, 64, 40, 40, 40, 2, 0));
    // Inner sizes that disagree with the grid, and values wider than the
    // border and absorb registers, which keep only their low ten bits.
    settings.push_back(make_regs(8191, 300, 64, 250, 10, 4000, 'h1C02, 'h1414));
    for (int r = 0; r < 2; r++) begin
      b  = $urandom_range(8);
      a  = (r == 0) ? $urandom_range(40, 1) : $urandom_range(3, 1);
      g  = $urandom_range(400, 2 * (b + a) + 1);
      rs = make_regs(g, g + $urandom_range(20), g - $urandom_range(1),
                     g - 2 * (b + a), g - 2 * (b + a) + 1, g - 2 * (b + a) - 1, b, a);
      settings.push_back(rs);
    end

    for (int phase = 0; phase <= settings.size(); phase++) begin
      if (phase > 0) begin
        wait_drained();
        load_regs(settings[phase-1]);
      end
      if (phase < 3) begin
        src_idle_pct  = 12;
        sink_idle_pct = 55;
      end else if (phase < 5) begin
        src_idle_pct  = 55;
        sink_idle_pct = 12;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      repeat ((phase == 0) ? 100 : 85) begin
        px = pick_coord(0);
        py = pick_coord(1);
        pz = pick_coord(2);
        sp = pick_sample();
        sq = pick_sample();
        push_point(px, py, pz, sp, sq, damp_point(px, py, pz, sp, sq));
      end
    end

    wait_drained();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
